@@ rtl/core/pfk_pkg.sv @@
package pfk_pkg;

	localparam int NUM_HUES  = 8;
	localparam int HUE_W     = 3;
	localparam int TBL_DEPTH = NUM_HUES * NUM_HUES;
	localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INNER = 2'd0,
		CFG_OUTER = 2'd1,
		CFG_SCALE = 2'd2
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] INNER_RST = 16'd1280;
	localparam logic [CFG_W-1:0] OUTER_RST = 16'd12800;
	localparam logic [CFG_W-1:0] SCALE_RST = 16'd256;

	localparam logic REQ_FORCE = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// square root: 48-bit radicand, one result bit per stage
	localparam int ROOT_IN_W  = 48;
	localparam int ROOT_W     = 24;
	localparam int ROOT_REM_W = 27;

	// restoring divider: one quotient bit per stage
	localparam int DIVD_W = 48;
	localparam int DIVR_W = 24;
	localparam int QUO_W  = 25;

	typedef struct packed {
		logic               req_type;
		logic [HUE_W-1:0]   hue_a;
		logic [HUE_W-1:0]   hue_b;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic signed [15:0] coeff_value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
	} out_word_t;

endpackage

@@ rtl/core/pfk_root.sv @@
module pfk_root (
	input  logic                           clk,
	input  logic                           en,
	input  logic [pfk_pkg::ROOT_IN_W-1:0]  radicand,
	output logic [pfk_pkg::ROOT_W-1:0]     root
);

	logic [pfk_pkg::ROOT_IN_W-1:0]  val_s [pfk_pkg::ROOT_W];
	logic [pfk_pkg::ROOT_REM_W-1:0] rem_s [pfk_pkg::ROOT_W];
	logic [pfk_pkg::ROOT_W-1:0]     res_s [pfk_pkg::ROOT_W];

	for (genvar k = 0; k < pfk_pkg::ROOT_W; k++) begin : g_step
		logic [pfk_pkg::ROOT_IN_W-1:0]  val_in;
		logic [pfk_pkg::ROOT_REM_W-1:0] rem_in;
		logic [pfk_pkg::ROOT_W-1:0]     res_in;
		logic [pfk_pkg::ROOT_REM_W-1:0] rem_sh;
		logic [pfk_pkg::ROOT_REM_W-1:0] trial;
		logic                           ge;

		if (k == 0) begin : g_first
			assign val_in = radicand;
			assign rem_in = '0;
			assign res_in = '0;
		end else begin : g_next
			assign val_in = val_s[k-1];
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end

		// bring down the next bit pair; trial is 4*res + 1
		assign rem_sh = {rem_in[pfk_pkg::ROOT_REM_W-3:0],
			val_in[pfk_pkg::ROOT_IN_W-1-2*k -: 2]};
		assign trial  = pfk_pkg::ROOT_REM_W'({res_in, 2'b01});
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k] <= val_in;
				rem_s[k] <= ge ? (rem_sh - trial) : rem_sh;
				res_s[k] <= {res_in[pfk_pkg::ROOT_W-2:0], ge};
			end
		end
	end

	assign root = res_s[pfk_pkg::ROOT_W-1];

endmodule

@@ rtl/core/pfk_quot.sv @@
module pfk_quot (
	input  logic                        clk,
	input  logic                        en,
	input  logic [pfk_pkg::DIVD_W-1:0]  dividend,
	input  logic [pfk_pkg::DIVR_W-1:0]  divisor,
	output logic [pfk_pkg::QUO_W-1:0]   quotient
);

	// caller keeps dividend below divisor * 2^QUO_W
	logic [pfk_pkg::DIVD_W-1:0] rem_s [pfk_pkg::QUO_W];
	logic [pfk_pkg::DIVR_W-1:0] den_s [pfk_pkg::QUO_W];
	logic [pfk_pkg::QUO_W-1:0]  quo_s [pfk_pkg::QUO_W];

	for (genvar k = 0; k < pfk_pkg::QUO_W; k++) begin : g_step
		logic [pfk_pkg::DIVD_W-1:0] rem_in;
		logic [pfk_pkg::DIVR_W-1:0] den_in;
		logic [pfk_pkg::QUO_W-1:0]  quo_in;
		logic [pfk_pkg::DIVD_W-1:0] trial;
		logic                       ge;

		if (k == 0) begin : g_first
			assign rem_in = dividend;
			assign den_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = pfk_pkg::DIVD_W'(den_in) << (pfk_pkg::QUO_W - 1 - k);
		assign ge    = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (rem_in - trial) : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[pfk_pkg::QUO_W-2:0], ge};
			end
		end
	end

	assign quotient = quo_s[pfk_pkg::QUO_W-1];

endmodule

@@ rtl/core/pair_force_kernel.sv @@
// channel   direction  handshake             word
// in        input      in_valid / in_ready   pfk_pkg::in_word_t
// out       output     out_valid / out_ready pfk_pkg::out_word_t
// cfg       input      cfg_we                cfg_idx, cfg_data
//
// One word per clock while the skid entry is empty. A force word passes stages s1 to
// s81 and then the output register; table writes produce no output word.
// Depth is set by the 24-stage root and the three 25-stage dividers (one for the
// ramp, two in parallel for x and y), one bit per stage each.
// arst_n clears valid bits and the coefficient valid bits and resets the config registers to their defaults.
// A two-entry output (register plus skid) lets the pipe run while a result waits;
// the whole pipe holds only when both entries are full.
module pair_force_kernel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pfk_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pfk_pkg::out_word_t            out_word,
	input  logic                          cfg_we,
	input  logic [pfk_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [pfk_pkg::CFG_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {RG_NEAR, RG_RISE, RG_FALL, RG_NONE} region_t;

	typedef struct packed {
		logic        zero;
		region_t     rg;
		logic [16:0] c2;
		logic [15:0] dx;
		logic [15:0] dy;
	} rside_t;

	typedef struct packed {
		logic        zero;
		logic        neg;
		logic [23:0] r;
		logic [15:0] dx;
		logic [15:0] dy;
	} qside_t;

	typedef struct packed {
		logic zero;
		logic sx;
		logic sy;
	} fside_t;

	// ---------------- config ----------------
	logic [15:0] inner_q, outer_q, scale_q;
	logic [31:0] inner_sq_q, outer_sq_q;
	logic [33:0] mid_sq_q;
	logic [16:0] midx2;
	logic [23:0] rmin16, mid16, rmax16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= pfk_pkg::INNER_RST;
			outer_q <= pfk_pkg::OUTER_RST;
			scale_q <= pfk_pkg::SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pfk_pkg::CFG_INNER: inner_q <= cfg_data;
				pfk_pkg::CFG_OUTER: outer_q <= cfg_data;
				pfk_pkg::CFG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign midx2  = {1'b0, inner_q} + {1'b0, outer_q};
	assign rmin16 = {inner_q, 8'd0};
	assign mid16  = {midx2, 7'd0};
	assign rmax16 = {outer_q, 8'd0};

	// region bounds, squared; refreshed every clock
	always_ff @(posedge clk) begin
		inner_sq_q <= inner_q * inner_q;
		outer_sq_q <= outer_q * outer_q;
		mid_sq_q   <= midx2 * midx2;
	end

	// ---------------- handshake ----------------
	logic skid_valid_q, out_valid_q;
	pfk_pkg::out_word_t skid_word_q, out_word_q;
	logic en, acc;

	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign acc      = in_valid && in_ready;

	// ---------------- coefficient table ----------------
	logic [15:0]                 coef_mem [pfk_pkg::TBL_DEPTH];
	logic [pfk_pkg::TBL_DEPTH-1:0] coef_vld_q;
	logic [pfk_pkg::TBL_AW-1:0]  tbl_idx;
	logic                        hue_ok, tbl_wr;

	assign hue_ok = (int'(in_word.hue_a) < pfk_pkg::NUM_HUES)
		&& (int'(in_word.hue_b) < pfk_pkg::NUM_HUES);
	assign tbl_idx = pfk_pkg::TBL_AW'(int'(in_word.hue_a) * pfk_pkg::NUM_HUES
		+ int'(in_word.hue_b));
	assign tbl_wr = acc && (in_word.req_type == pfk_pkg::REQ_WRITE) && hue_ok;

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			coef_mem[tbl_idx] <= in_word.coeff_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (tbl_wr) begin
			coef_vld_q[tbl_idx] <= 1'b1;
		end
	end

	// ---------------- s1: squares, table read ----------------
	logic               v_s1, cok_s1;
	logic signed [31:0] sqx_s1, sqy_s1;
	logic [15:0]        dx_s1, dy_s1, coef_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && (in_word.req_type == pfk_pkg::REQ_FORCE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= in_word.offset_x;
			dy_s1   <= in_word.offset_y;
			sqx_s1  <= in_word.offset_x * in_word.offset_x;
			sqy_s1  <= in_word.offset_y * in_word.offset_y;
			coef_s1 <= coef_mem[tbl_idx];
			cok_s1  <= coef_vld_q[tbl_idx] && hue_ok;
		end
	end

	// ---------------- s2: d2, doubled coefficient ----------------
	logic        v_s2;
	logic [31:0] d2_s2;
	logic [16:0] c2_s2;
	logic [15:0] dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s2 <= $unsigned(sqx_s1) + $unsigned(sqy_s1);
			c2_s2 <= cok_s1 ? {coef_s1, 1'b0} : 17'd0;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
		end
	end

	// ---------------- s3..s26: region, root ----------------
	region_t rg_c;

	// a distance on a bound belongs to the inner region
	always_comb begin
		priority if (d2_s2 <= inner_sq_q) begin
			rg_c = RG_NEAR;
		end else if ({d2_s2, 2'b00} <= mid_sq_q) begin
			rg_c = RG_RISE;
		end else if (d2_s2 <= outer_sq_q) begin
			rg_c = RG_FALL;
		end else begin
			rg_c = RG_NONE;
		end
	end

	rside_t                    rs_s [pfk_pkg::ROOT_W];
	logic [pfk_pkg::ROOT_W-1:0] rv_s;
	logic [pfk_pkg::ROOT_W-1:0] r_root;
	rside_t                    rs_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s <= '0;
		end else if (en) begin
			rv_s <= {rv_s[pfk_pkg::ROOT_W-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s[0] <= '{zero: (d2_s2 == 32'd0), rg: rg_c, c2: c2_s2,
				dx: dx_s2, dy: dy_s2};
			for (int k = 1; k < pfk_pkg::ROOT_W; k++) begin
				rs_s[k] <= rs_s[k-1];
			end
		end
	end

	pfk_root u_root (
		.clk      (clk),
		.en       (en),
		.radicand ({d2_s2, 16'd0}),
		.root     (r_root)
	);

	assign rs_end = rs_s[pfk_pkg::ROOT_W-1];

	// ---------------- s27: ramp operands ----------------
	logic [16:0] c2_mag, a_c;
	logic [23:0] num_c, den_c;
	logic        neg_c;

	assign c2_mag = rs_end.c2[16] ? (~rs_end.c2 + 17'd1) : rs_end.c2;

	always_comb begin
		unique case (rs_end.rg)
			RG_NEAR: begin
				a_c   = 17'h10000;
				num_c = rmin16 - r_root;
				den_c = rmin16;
				neg_c = 1'b0;
			end
			RG_RISE: begin
				a_c   = c2_mag;
				num_c = r_root - rmin16;
				den_c = mid16 - rmin16;
				neg_c = rs_end.c2[16];
			end
			RG_FALL: begin
				a_c   = c2_mag;
				num_c = rmax16 - r_root;
				den_c = rmax16 - mid16;
				neg_c = rs_end.c2[16];
			end
			default: begin
				a_c   = 17'd0;
				num_c = 24'd0;
				den_c = 24'd1;
				neg_c = 1'b0;
			end
		endcase
	end

	logic        v_s27;
	logic [16:0] a_s27;
	logic [23:0] num_s27, den_s27;
	qside_t      qd_s27;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s27 <= 1'b0;
		end else if (en) begin
			v_s27 <= rv_s[pfk_pkg::ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s27   <= a_c;
			num_s27 <= num_c;
			den_s27 <= den_c;
			qd_s27  <= '{zero: rs_end.zero, neg: neg_c, r: r_root,
				dx: rs_end.dx, dy: rs_end.dy};
		end
	end

	// ---------------- s28: ramp product ----------------
	logic        v_s28;
	logic [40:0] prod_s28;
	logic [23:0] den_s28;
	qside_t      qd_s28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s28 <= 1'b0;
		end else if (en) begin
			v_s28 <= v_s27;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s28 <= a_s27 * num_s27;
			den_s28  <= den_s27;
			qd_s28   <= qd_s27;
		end
	end

	// ---------------- s29..s53: ramp divide ----------------
	qside_t                    qs_s [pfk_pkg::QUO_W];
	logic [pfk_pkg::QUO_W-1:0] qv_s;
	logic [pfk_pkg::QUO_W-1:0] m_quo;
	qside_t                    qs_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s <= '0;
		end else if (en) begin
			qv_s <= {qv_s[pfk_pkg::QUO_W-2:0], v_s28};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qs_s[0] <= qd_s28;
			for (int k = 1; k < pfk_pkg::QUO_W; k++) begin
				qs_s[k] <= qs_s[k-1];
			end
		end
	end

	pfk_quot u_ramp (
		.clk      (clk),
		.en       (en),
		.dividend (pfk_pkg::DIVD_W'(prod_s28)),
		.divisor  (den_s28),
		.quotient (m_quo)
	);

	assign qs_end = qs_s[pfk_pkg::QUO_W-1];

	// ---------------- s54: magnitude times scale ----------------
	logic        v_s54;
	logic [32:0] mfs_s54;
	qside_t      qd_s54;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s54 <= 1'b0;
		end else if (en) begin
			v_s54 <= qv_s[pfk_pkg::QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mfs_s54 <= m_quo[16:0] * scale_q;
			qd_s54  <= qs_end;
		end
	end

	// ---------------- s55: times |dx|, |dy| ----------------
	logic [15:0] ax_c, ay_c;
	logic [48:0] mulx_c, muly_c;

	assign ax_c   = qd_s54.dx[15] ? (~qd_s54.dx + 16'd1) : qd_s54.dx;
	assign ay_c   = qd_s54.dy[15] ? (~qd_s54.dy + 16'd1) : qd_s54.dy;
	assign mulx_c = mfs_s54 * ax_c;
	assign muly_c = mfs_s54 * ay_c;

	logic        v_s55;
	logic [47:0] px_s55, py_s55;
	logic [23:0] r_s55;
	fside_t      fd_s55;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s55 <= 1'b0;
		end else if (en) begin
			v_s55 <= v_s54;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s55 <= mulx_c[47:0];
			py_s55 <= muly_c[47:0];
			r_s55  <= qd_s54.r;
			fd_s55 <= '{zero: qd_s54.zero, sx: qd_s54.neg ^ qd_s54.dx[15],
				sy: qd_s54.neg ^ qd_s54.dy[15]};
		end
	end

	// ---------------- s56..s80: divide by r ----------------
	fside_t                    fs_s [pfk_pkg::QUO_W];
	logic [pfk_pkg::QUO_W-1:0] fv_s;
	logic [pfk_pkg::QUO_W-1:0] qx, qy;
	fside_t                    fs_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s <= '0;
		end else if (en) begin
			fv_s <= {fv_s[pfk_pkg::QUO_W-2:0], v_s55};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fs_s[0] <= fd_s55;
			for (int k = 1; k < pfk_pkg::QUO_W; k++) begin
				fs_s[k] <= fs_s[k-1];
			end
		end
	end

	pfk_quot u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (px_s55),
		.divisor  (r_s55),
		.quotient (qx)
	);

	pfk_quot u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (py_s55),
		.divisor  (r_s55),
		.quotient (qy)
	);

	assign fs_end = fs_s[pfk_pkg::QUO_W-1];

	// ---------------- s81: sign, zero offset ----------------
	// |force| <= scale * 2^16 / 256 < 2^25, so the 25-bit quotient never overflows
	logic [25:0]        sval_x, sval_y;
	pfk_pkg::out_word_t fin_c;

	assign sval_x = fs_end.sx ? (~{1'b0, qx} + 26'd1) : {1'b0, qx};
	assign sval_y = fs_end.sy ? (~{1'b0, qy} + 26'd1) : {1'b0, qy};

	always_comb begin
		if (fs_end.zero) begin
			fin_c.force_x = {8'd0, scale_q, 8'd0};
			fin_c.force_y = 32'sd0;
		end else begin
			fin_c.force_x = {{6{sval_x[25]}}, sval_x};
			fin_c.force_y = {{6{sval_y[25]}}, sval_y};
		end
	end

	logic               v_s81;
	pfk_pkg::out_word_t fin_s81;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s81 <= 1'b0;
		end else if (en) begin
			v_s81 <= fv_s[pfk_pkg::QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s81 <= fin_c;
		end
	end

	// ---------------- output register + skid ----------------
	logic push, out_free;

	assign push     = en && v_s81;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_word_q <= skid_valid_q ? skid_word_q : fin_s81;
		end else if (push) begin
			skid_word_q <= fin_s81;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// ---------------- checks ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");

	// zero offset with zero inner radius divides by zero; its result is replaced
	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(qv_s[pfk_pkg::QUO_W-1] && !qs_end.zero) |-> (m_quo <= 25'h10000))
		else $error("ramp magnitude above one");

	a_near_root: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_s[pfk_pkg::ROOT_W-1] && !rs_end.zero && (rs_end.rg == RG_NEAR))
		|-> (r_root <= rmin16))
		else $error("root past inner radius in repulsion region");

	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_s[pfk_pkg::ROOT_W-1] && !rs_end.zero) |-> (r_root != '0))
		else $error("zero root for nonzero offset");

endmodule
